// ----- rtl/arrb_pkg.sv -----
// ----------------------------------------------------------------------------
// arrb_pkg
// Shared types and constants for the adaptive resampling ring buffer.
// ----------------------------------------------------------------------------
package arrb_pkg;

  // sample and slot widths
  localparam int SAMPLE_W = 24;
  localparam int WORD_W   = 32;
  localparam int FRAC_W   = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [WORD_W-1:0]   word_t;

  // saturation bounds of a 24-bit sample
  localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN = 24'sh800000;

  // input commands carried on tuser
  localparam logic CMD_PUSH    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // configuration register indexes
  localparam logic CFG_TARGET_FILL = 1'b0;
  localparam logic CFG_STEP_LIMIT  = 1'b1;

  // configuration reset values
  localparam logic [7:0]  TARGET_FILL_RST = 8'd128;
  localparam logic [12:0] STEP_LIMIT_RST  = 13'd128;

endpackage

// ----- rtl/arrb_ring.sv -----
// ----------------------------------------------------------------------------
// arrb_ring
// Stereo frame memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module arrb_ring
  import arrb_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  sample_t                  wr_left,
  input  sample_t                  wr_right,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output sample_t                  rd_left,
  output sample_t                  rd_right
);

  logic [2*SAMPLE_W-1:0] mem [DEPTH];
  logic [2*SAMPLE_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_right, wr_left};
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_left  = sample_t'(rd_data_r[SAMPLE_W-1:0]);
  assign rd_right = sample_t'(rd_data_r[2*SAMPLE_W-1:SAMPLE_W]);

endmodule

// ----- rtl/arrb_interp.sv -----
// ----------------------------------------------------------------------------
// arrb_interp
// Shared interpolation unit: registered (b - a) * frac, then add, clamp, pack.
// ----------------------------------------------------------------------------
module arrb_interp
  import arrb_pkg::*;
(
  input  logic              clk,
  input  logic              mul_en,
  input  sample_t           a,
  input  sample_t           b,
  input  logic [FRAC_W-1:0] frac,
  output word_t             word
);

  localparam int DW = SAMPLE_W + 1;
  localparam int PW = DW + FRAC_W + 1;
  localparam int SW = PW - FRAC_W;

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_r;
  sample_t              base_r;
  logic signed [SW-1:0] delta;
  logic signed [SW-1:0] sum;
  sample_t              sat;

  // difference and product
  assign diff = DW'(b) - DW'(a);
  assign prod = PW'(diff) * $signed({1'b0, frac});

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod;
      base_r <= a;
    end
  end

  // floor shift, add base, saturate
  assign delta = prod_r[PW-1:FRAC_W];
  assign sum   = SW'(base_r) + delta;

  always_comb begin
    if (sum > SW'(SAMPLE_MAX)) begin
      sat = SAMPLE_MAX;
    end else if (sum < SW'(SAMPLE_MIN)) begin
      sat = SAMPLE_MIN;
    end else begin
      sat = sum[SAMPLE_W-1:0];
    end
  end

  assign word = {sat, {(WORD_W-SAMPLE_W){1'b0}}};

endmodule

// ----- rtl/adaptive_resampling_ring_buffer_unit.sv -----
// Push beat: after accept the unit passes through ST_PUSH before the next beat
// can be taken. Block request: a rate-loop update (ST_FILT, ST_STEP), then per
// output frame ST_CHECK, ST_RD1, ST_MULL, ST_MULR, ST_SUMR and ST_EMIT (two ring
// reads through the single read port, two passes through the shared multiplier);
// an underrun frame goes from ST_CHECK to ST_EMIT. Reset: synchronous; afterwards
// a clearing pass writes zero to every ring entry, during which no input beat is accepted.
// ----------------------------------------------------------------------------
// adaptive_resampling_ring_buffer_unit
// Ring buffer with a fill-level rate loop and linear-interpolating readout.
// ----------------------------------------------------------------------------
module adaptive_resampling_ring_buffer_unit
  import arrb_pkg::*;
#(
  parameter int RING_DEPTH   = 256,
  parameter int BLOCK_FRAMES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // left_sample[23:0], right_sample[47:24]
  input  logic         in_tuser,   // command
  // output stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // left_word, right_word, underrun_total,
                                   // overflow_total
  output logic         out_tlast,
  output logic         out_tuser,  // underrun
  // configuration
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [12:0]  cfg_wdata
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int PW = AW + FRAC_W;
  localparam int KW = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;
  localparam int EW = 18;

  localparam logic [AW-1:0] NEAR_FULL = AW'(RING_DEPTH - 2);
  localparam logic [AW-1:0] MIN_FILL  = AW'(2);
  localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
  localparam logic [KW-1:0] LAST_K    = KW'(BLOCK_FRAMES - 1);

  // sequencer states
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_PUSH  = 4'd2;
  localparam logic [3:0] ST_FILT  = 4'd3;
  localparam logic [3:0] ST_STEP  = 4'd4;
  localparam logic [3:0] ST_CHECK = 4'd5;
  localparam logic [3:0] ST_RD1   = 4'd6;
  localparam logic [3:0] ST_MULL  = 4'd7;
  localparam logic [3:0] ST_MULR  = 4'd8;
  localparam logic [3:0] ST_SUMR  = 4'd9;
  localparam logic [3:0] ST_EMIT  = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_r;
  logic [AW-1:0]     wi_r;
  logic [PW-1:0]     pos_r;
  logic signed [15:0] fe_r;
  logic [17:0]       step_r;
  logic [KW-1:0]     k_r;
  logic [31:0]       urun_cnt_r;
  logic [31:0]       ovf_cnt_r;
  logic [7:0]        target_r;
  logic [12:0]       limit_r;
  sample_t           push_l_r, push_r_r;
  sample_t           a_l_r, a_r_r;
  word_t             word_l_r, word_r_r;
  logic              flag_r;

  logic              out_valid_r;
  word_t             out_l_r, out_r_r;
  logic [31:0]       out_utot_r, out_otot_r;
  logic              out_last_r, out_flag_r;

  // ring ports
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  sample_t           wr_left, wr_right;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  sample_t           rd_left, rd_right;

  // interpolation unit ports
  logic              mul_en;
  sample_t           mul_a, mul_b;
  word_t             mul_word;

  logic              in_fire;
  logic              out_free;
  logic [AW-1:0]     rd_idx;
  logic [AW-1:0]     fill;
  logic signed [EW-1:0] err;
  logic signed [EW-1:0] fe_diff;
  logic signed [EW-1:0] fe_sum;
  logic signed [16:0]   lim_s;
  logic signed [16:0]   fe_ext;
  logic signed [16:0]   delta;
  logic signed [18:0]   step_sum;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // fill level and rate-loop arithmetic
  assign rd_idx  = pos_r[PW-1:FRAC_W];
  assign fill    = wi_r - rd_idx;
  assign err     = $signed({{(EW-AW){1'b0}}, fill}) - $signed({{(EW-8){1'b0}}, target_r});
  assign fe_diff = err - EW'(fe_r);
  assign fe_sum  = EW'(fe_r) + (fe_diff >>> 4);
  assign lim_s   = $signed({4'b0, limit_r});
  assign fe_ext  = 17'(fe_r);

  always_comb begin
    if (fe_ext < -lim_s) begin
      delta = -lim_s;
    end else if (fe_ext > lim_s) begin
      delta = lim_s;
    end else begin
      delta = fe_ext;
    end
  end

  assign step_sum = 19'sh10000 + 19'(delta);

  // ring access steering
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = wi_r;
    wr_left  = push_l_r;
    wr_right = push_r_r;
    if (state_r == ST_CLEAR) begin
      wr_en    = 1'b1;
      wr_addr  = clr_r;
      wr_left  = '0;
      wr_right = '0;
    end else if (state_r == ST_PUSH) begin
      wr_en = 1'b1;
    end
  end

  assign rd_en   = (state_r == ST_CHECK) || (state_r == ST_RD1);
  assign rd_addr = (state_r == ST_RD1) ? rd_idx + AW'(1) : rd_idx;

  // shared multiplier operand select
  assign mul_en = (state_r == ST_MULL) || (state_r == ST_MULR);
  assign mul_a  = (state_r == ST_MULR) ? a_r_r : a_l_r;
  assign mul_b  = (state_r == ST_MULR) ? rd_right : rd_left;

  arrb_ring #(
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_left  (wr_left),
    .wr_right (wr_right),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_left  (rd_left),
    .rd_right (rd_right)
  );

  arrb_interp u_interp (
    .clk    (clk),
    .mul_en (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .frac   (pos_r[FRAC_W-1:0]),
    .word   (mul_word)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) state_nxt = (in_tuser == CMD_PUSH) ? ST_PUSH : ST_FILT;
      end
      ST_PUSH:  state_nxt = ST_IDLE;
      ST_FILT:  state_nxt = ST_STEP;
      ST_STEP:  state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = (fill >= MIN_FILL) ? ST_RD1 : ST_EMIT;
      ST_RD1:   state_nxt = ST_MULL;
      ST_MULL:  state_nxt = ST_MULR;
      ST_MULR:  state_nxt = ST_SUMR;
      ST_SUMR:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_nxt = (k_r == LAST_K) ? ST_IDLE : ST_CHECK;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      wi_r       <= '0;
      pos_r      <= '0;
      fe_r       <= '0;
      k_r        <= '0;
      urun_cnt_r <= '0;
      ovf_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      // push: drop the oldest frame when near full
      if (state_r == ST_PUSH) begin
        wi_r <= wi_r + AW'(1);
        if (fill >= NEAR_FULL) begin
          pos_r     <= pos_r + (PW'(1) << FRAC_W);
          ovf_cnt_r <= ovf_cnt_r + 32'd1;
        end
      end
      if (state_r == ST_FILT) begin
        fe_r <= fe_sum[15:0];
        k_r  <= '0;
      end
      // frame handoff to the output register
      if (state_r == ST_EMIT && out_free) begin
        pos_r <= pos_r + PW'(step_r);
        k_r   <= k_r + KW'(1);
        if (flag_r) urun_cnt_r <= urun_cnt_r + 32'd1;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_FILL_RST;
      limit_r  <= STEP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_FILL: target_r <= cfg_wdata[7:0];
        CFG_STEP_LIMIT:  limit_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      push_l_r <= sample_t'(in_tdata[23:0]);
      push_r_r <= sample_t'(in_tdata[47:24]);
    end
    if (state_r == ST_STEP) begin
      step_r <= step_sum[17:0];
    end
    if (state_r == ST_CHECK) begin
      flag_r   <= (fill < MIN_FILL);
      word_l_r <= '0;
      word_r_r <= '0;
    end
    if (state_r == ST_RD1) begin
      a_l_r <= rd_left;
      a_r_r <= rd_right;
    end
    if (state_r == ST_MULR) begin
      word_l_r <= mul_word;
    end
    if (state_r == ST_SUMR) begin
      word_r_r <= mul_word;
    end
    if (state_r == ST_EMIT && out_free) begin
      out_l_r    <= word_l_r;
      out_r_r    <= word_r_r;
      out_flag_r <= flag_r;
      out_last_r <= (k_r == LAST_K);
      out_utot_r <= urun_cnt_r + {31'd0, flag_r};
      out_otot_r <= ovf_cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_otot_r, out_utot_r, out_r_r, out_l_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_flag_r;

endmodule

// ----- bench/adaptive_resampling_ring_buffer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// adaptive_resampling_ring_buffer_unit_tb
// Drives push and block-request beats into the resampling ring buffer. A
// local model predicts every output frame: interpolated samples, underrun
// flags, end-of-block marks and both running counters. Each output beat is
// checked against the oldest predicted frame. Both stream sides idle at
// random, and the receiver also holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module adaptive_resampling_ring_buffer_unit_tb
  import arrb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_FRAMES    = 256;
  localparam int BLOCK_LEN      = 64;
  localparam int IDX_W          = $clog2(RING_FRAMES);
  localparam int POS_W          = IDX_W + FRAC_W;
  localparam int STEP_ONE       = 1 << FRAC_W;
  localparam int PUSH_SETTLE    = 8;
  localparam int HOLD_CYCLES    = 1500;
  localparam int DRAIN_CYCLES   = 6 * BLOCK_LEN + 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    word_t       left_word;
    word_t       right_word;
    logic        underrun;
    logic        last;
    logic [31:0] underrun_total;
    logic [31:0] overflow_total;
  } out_frame_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  // block ports
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata   = '0;  // left_sample, right_sample
  logic         in_tuser   = 1'b0; // command
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;        // left_word, right_word, underrun_total,
                                  // overflow_total
  logic         out_tlast;
  logic         out_tuser;        // underrun
  logic         cfg_we     = 1'b0;
  logic         cfg_index  = 1'b0;
  logic [12:0]  cfg_wdata  = '0;

  adaptive_resampling_ring_buffer_unit #(
    .RING_DEPTH  (RING_FRAMES),
    .BLOCK_FRAMES(BLOCK_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predicted ring and rate-loop state
  sample_t            fifo_left  [RING_FRAMES] = '{default: '0};
  sample_t            fifo_right [RING_FRAMES] = '{default: '0};
  logic [IDX_W-1:0]   wr_ptr       = '0;
  logic [POS_W-1:0]   rd_pos       = '0;
  int                 err_lp       = 0;
  logic [31:0]        underrun_cnt = '0;
  logic [31:0]        overflow_cnt = '0;
  logic [7:0]         aim_fill     = TARGET_FILL_RST;
  logic [12:0]        step_cap     = STEP_LIMIT_RST;

  out_frame_t pending_frames[$];
  int         mismatches   = 0;
  int         frames_seen  = 0;
  int         beats_sent   = 0;
  int         tx_idle_pct  = 10;
  int         rx_idle_pct  = 74;
  int         hold_left    = 0;

  // frames held between the fractional read position and the write pointer
  function automatic logic [IDX_W-1:0] ring_fill(logic [POS_W-1:0] pos);
    return wr_ptr - pos[POS_W-1:FRAC_W];
  endfunction

  // interpolate between two samples and pack left-justified into a slot
  function automatic word_t blend_pack(sample_t a, sample_t b, logic [FRAC_W-1:0] frac);
    longint diff;
    longint val;
    diff = longint'(b) - longint'(a);
    val  = longint'(a) + ((diff * longint'(frac)) >>> FRAC_W);
    if (val > longint'(SAMPLE_MAX)) val = longint'(SAMPLE_MAX);
    if (val < longint'(SAMPLE_MIN)) val = longint'(SAMPLE_MIN);
    return {val[SAMPLE_W-1:0], {(WORD_W-SAMPLE_W){1'b0}}};
  endfunction

  // push: drop the oldest frame when nearly full, then write
  function automatic void predict_push(sample_t l, sample_t r);
    if (ring_fill(rd_pos) >= RING_FRAMES - 2) begin
      rd_pos = POS_W'(rd_pos + STEP_ONE);
      overflow_cnt++;
    end
    fifo_left[wr_ptr]  = l;
    fifo_right[wr_ptr] = r;
    wr_ptr++;
  endfunction

  // request: update the rate loop, then queue one block of frames
  function automatic void predict_block();
    logic [POS_W-1:0]  pos;
    logic [IDX_W-1:0]  i0;
    logic [IDX_W-1:0]  i1;
    logic [FRAC_W-1:0] frac;
    int                err;
    int                step;
    int                k;
    out_frame_t        f;
    pos    = rd_pos;
    err    = int'(ring_fill(pos)) - int'(aim_fill);
    err_lp = err_lp + ((err - err_lp) >>> 4);
    step   = STEP_ONE + err_lp;
    if (step < STEP_ONE - int'(step_cap)) step = STEP_ONE - int'(step_cap);
    if (step > STEP_ONE + int'(step_cap)) step = STEP_ONE + int'(step_cap);
    for (k = 0; k < BLOCK_LEN; k++) begin
      i0   = pos[POS_W-1:FRAC_W];
      i1   = i0 + 1'b1;
      frac = pos[FRAC_W-1:0];
      f    = '0;
      if (ring_fill(pos) >= 2) begin
        f.left_word  = blend_pack(fifo_left[i0], fifo_left[i1], frac);
        f.right_word = blend_pack(fifo_right[i0], fifo_right[i1], frac);
      end else begin
        underrun_cnt++;
        f.underrun = 1'b1;
      end
      f.last           = (k == BLOCK_LEN - 1);
      f.underrun_total = underrun_cnt;
      f.overflow_total = overflow_cnt;
      pending_frames.push_back(f);
      pos = POS_W'(pos + step);
    end
    rd_pos = pos;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // one input beat; valid stays high into the next call unless it idles
  task automatic send_beat(input logic cmd, input sample_t l, input sample_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {r, l};
    do begin
      @(posedge clk);
    end while (in_tready !== 1'b1);
    if (cmd == CMD_PUSH) predict_push(l, r);
    else predict_block();
    beats_sent++;
  endtask

  task automatic send_request();
    send_beat(CMD_REQUEST, sample_t'($urandom), sample_t'($urandom));
  endtask

  // stop sending, wait for every frame, and let a last push finish
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (PUSH_SETTLE) @(posedge clk);
  endtask

  // both registers, back to back; only called after settle
  task automatic write_regs(input logic [12:0] fill_word, input logic [12:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TARGET_FILL;
    cfg_wdata <= fill_word;
    @(posedge clk);
    cfg_index <= CFG_STEP_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we   <= 1'b0;
    aim_fill = fill_word[7:0];
    step_cap = limit;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t frame %0d %s: got %h want %h", $time, frames_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // receiver: random idling, or a counted hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // compare each output beat with the oldest predicted frame
  always @(posedge clk) begin
    out_frame_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("beat with no frame pending", out_tdata[31:0], '0);
      end else begin
        want = pending_frames.pop_front();
        check_field("left_word", out_tdata[31:0], want.left_word);
        check_field("right_word", out_tdata[63:32], want.right_word);
        check_field("underrun_total", out_tdata[95:64], want.underrun_total);
        check_field("overflow_total", out_tdata[127:96], want.overflow_total);
        check_field("underrun", 32'(out_tuser), 32'(want.underrun));
        check_field("last", 32'(out_tlast), 32'(want.last));
      end
      frames_seen++;
    end
  end

  // watchdog on cycles with no beat moving on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[adaptive_resampling_ring_buffer_unit] ERROR");
    $finish;
  end

  // full-scale frames, interpolation into underrun, then reads past the writer
  task automatic test_sample_extremes();
    send_beat(CMD_PUSH, SAMPLE_MAX, SAMPLE_MIN);
    send_beat(CMD_PUSH, SAMPLE_MIN, SAMPLE_MAX);
    send_beat(CMD_PUSH, '0, sample_t'(-1));
    send_beat(CMD_PUSH, sample_t'(-1), '0);
    send_beat(CMD_PUSH, SAMPLE_MAX, SAMPLE_MAX);
    send_beat(CMD_PUSH, SAMPLE_MIN, SAMPLE_MIN);
    send_beat(CMD_PUSH, 24'sh555555, 24'shAAAAAA);
    send_beat(CMD_PUSH, 24'shAAAAAA, 24'sh555555);
    send_request();
    send_request();
    settle();
  endtask

  // target and step limit at both ends, upper data bits on the target write
  task automatic test_register_extremes();
    write_regs({5'h1F, 8'd0}, 13'd0);
    send_beat(CMD_PUSH, pick_sample(), pick_sample());
    send_beat(CMD_PUSH, pick_sample(), pick_sample());
    send_request();
    settle();
    write_regs({5'h00, 8'd255}, 13'h1FFF);
    repeat (3) send_beat(CMD_PUSH, pick_sample(), pick_sample());
    send_request();
    settle();
  endtask

  // push past a full ring so the oldest frames get dropped
  task automatic test_ring_overflow();
    write_regs(13'd253, 13'd4096);
    repeat (RING_FRAMES + 4) send_beat(CMD_PUSH, pick_sample(), pick_sample());
    send_request();
    send_request();
    settle();
  endtask

  // receiver holds off while beats keep coming, so the input stalls
  task automatic test_output_backpressure();
    hold_left <= HOLD_CYCLES;
    repeat (3) begin
      repeat (6) send_beat(CMD_PUSH, pick_sample(), pick_sample());
      send_request();
    end
    settle();
  endtask

  // runs of pushes closed by a request, with some short broken runs
  task automatic test_random_traffic(input int count);
    int first;
    int run_len;
    first = beats_sent;
    while (beats_sent - first < count) begin
      if ($urandom_range(5) == 0) run_len = $urandom_range(3);
      else run_len = $urandom_range(8, 72);
      repeat (run_len) send_beat(CMD_PUSH, pick_sample(), pick_sample());
      send_request();
    end
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sample_extremes();
    test_register_extremes();
    test_ring_overflow();
    test_output_backpressure();

    write_regs(13'd2, 13'd64);
    test_random_traffic(20);

    tx_idle_pct = 74;
    rx_idle_pct <= 10;
    write_regs(13'($urandom_range(2, 253)), 13'($urandom_range(0, 4096)));
    test_random_traffic(20);

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    write_regs(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
    test_random_traffic(20);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[adaptive_resampling_ring_buffer_unit] OK");
    else
      $display("[adaptive_resampling_ring_buffer_unit] ERROR");
    $finish;
  end

endmodule
